// ===== src/efr_pkg.sv =====
// Package for the escaped frame receiver: register codes, reset values,
// configuration struct and check-value helper functions. No dependencies.
package efr_pkg;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_ONE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_TWO = 2'd2;

	localparam logic [7:0] CRC_POLY_RST = 8'd7;
	localparam logic [7:0] TRIG_ONE_RST = 8'd129;
	localparam logic [7:0] TRIG_TWO_RST = 8'd136;

	localparam logic RESULT_PAYLOAD = 1'b0;
	localparam logic RESULT_SUMMARY = 1'b1;

	localparam logic [6:0] HDR_BYTES = 7'd3;

	typedef logic [7:0][7:0] crc_tbl_t;

	typedef struct packed {
		logic [7:0] trig_one;
		logic [7:0] trig_two;
		crc_tbl_t   tbl;
	} cfg_t;

	// Column i: eight shift steps applied to a value holding only bit i.
	function automatic crc_tbl_t crc_tbl_calc(input logic [7:0] poly);
		crc_tbl_t t;
		logic [7:0] v;
		for (int i = 0; i < 8; i++) begin
			v = 8'(1 << i);
			for (int s = 0; s < 8; s++) begin
				v = v[7] ? ({v[6:0], 1'b0} ^ poly) : {v[6:0], 1'b0};
			end
			t[i] = v;
		end
		return t;
	endfunction

	function automatic logic [7:0] crc_shift8(input crc_tbl_t t, input logic [7:0] c);
		logic [7:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (c[i]) r = r ^ t[i];
		end
		return r;
	endfunction

	function automatic logic [7:0] crc_byte(input crc_tbl_t t, input logic [7:0] c,
		input logic [7:0] b);
		logic [7:0] r;
		r = c;
		for (int k = 0; k < 8; k++) begin
			r = crc_shift8(t, {r[7:1], r[0] ^ b[7-k]});
		end
		return r;
	endfunction

endpackage

// ===== src/efr_in_if.sv =====
// Input channel: one wire byte per transfer.
// Depends on nothing.
interface efr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] wire_byte;
	logic       frame_start;

	modport source (output valid, output wire_byte, output frame_start, input ready);
	modport sink (input valid, input wire_byte, input frame_start, output ready);
endinterface

// ===== src/efr_out_if.sv =====
// Result channel: payload byte or end-of-frame summary per transfer.
// Depends on nothing.
interface efr_out_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] payload_byte;
	logic [5:0] payload_index;
	logic [7:0] frame_marker;
	logic [5:0] payload_length;
	logic [4:0] sequence_number;
	logic [4:0] frame_type;
	logic [7:0] received_check;
	logic       check_ok;

	modport source (output valid, output result_kind, output payload_byte,
		output payload_index, output frame_marker, output payload_length,
		output sequence_number, output frame_type, output received_check,
		output check_ok, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input payload_index, input frame_marker, input payload_length,
		input sequence_number, input frame_type, input received_check,
		input check_ok, output ready);
endinterface

// ===== src/efr_cfg_if.sv =====
// Configuration write channel: register index and data per transfer.
// Depends on nothing.
interface efr_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/efr_cfg_regs.sv =====
// Configuration registers and the registered check-value column table.
// Depends on efr_pkg and efr_cfg_if.
module efr_cfg_regs
	import efr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	efr_cfg_if.sink   cfg,
	output cfg_t      cfg_o
);

	logic [7:0] trig_one_q;
	logic [7:0] trig_two_q;
	crc_tbl_t   tbl_q;

	assign cfg.ready = 1'b1;

	// table follows the polynomial write at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_one_q <= TRIG_ONE_RST;
			trig_two_q <= TRIG_TWO_RST;
			tbl_q      <= crc_tbl_calc(CRC_POLY_RST);
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_CRC_POLY: tbl_q      <= crc_tbl_calc(cfg.data);
					REG_TRIG_ONE: trig_one_q <= cfg.data;
					REG_TRIG_TWO: trig_two_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	assign cfg_o.trig_one = trig_one_q;
	assign cfg_o.trig_two = trig_two_q;
	assign cfg_o.tbl      = tbl_q;

endmodule

// ===== src/efr_frame_core.sv =====
// Frame parser: input register, frame state, check update and result register.
// Depends on efr_pkg, efr_in_if and efr_out_if.
module efr_frame_core
	import efr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg_i,
	efr_in_if.sink    in_ch,
	efr_out_if.source out_ch
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	logic       drop_q, active_q;
	logic [6:0] pos_q;
	logic [7:0] marker_q, hdr1_q, hdr2_q, crc_q;

	logic       out_valid_q;
	logic       kind_q, ok_q;
	logic [7:0] pbyte_q, rcheck_q;
	logic [5:0] pidx_q;

	logic       advance;
	logic       proceed;
	logic [6:0] pos_b;
	logic [7:0] crc_b, crc_upd;
	logic [5:0] len;
	logic       in_payload;

	logic       drop_n, active_n;
	logic [6:0] pos_n;
	logic [7:0] marker_n, hdr1_n, hdr2_n, crc_n;
	logic       emit, kind_n;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	assign proceed    = start_s1 || (active_q && !drop_q);
	assign pos_b      = start_s1 ? 7'd0 : pos_q;
	assign crc_b      = start_s1 ? 8'd0 : crc_q;
	assign crc_upd    = crc_byte(cfg_i.tbl, crc_b, byte_s1);
	assign len        = hdr1_q[7:2];
	assign in_payload = pos_b < (HDR_BYTES + {1'b0, len});

	always_comb begin
		drop_n   = drop_q;
		active_n = active_q;
		pos_n    = pos_b;
		crc_n    = crc_b;
		marker_n = marker_q;
		hdr1_n   = hdr1_q;
		hdr2_n   = hdr2_q;
		emit     = 1'b0;
		kind_n   = RESULT_PAYLOAD;
		if (start_s1) begin
			active_n = 1'b1;
			drop_n   = 1'b0;
		end else if (active_q && drop_q) begin
			drop_n = 1'b0;
		end
		if (proceed) begin
			if (byte_s1 == cfg_i.trig_one || byte_s1 == cfg_i.trig_two) drop_n = 1'b1;
			case (pos_b)
				7'd0: begin
					marker_n = byte_s1;
					pos_n    = 7'd1;
				end
				7'd1: begin
					hdr1_n = byte_s1;
					crc_n  = crc_upd;
					pos_n  = 7'd2;
				end
				7'd2: begin
					hdr2_n = byte_s1;
					crc_n  = crc_upd;
					pos_n  = 7'd3;
				end
				default: begin
					emit = 1'b1;
					if (in_payload) begin
						crc_n = crc_upd;
						pos_n = pos_b + 7'd1;
					end else begin
						kind_n   = RESULT_SUMMARY;
						active_n = 1'b0;
						drop_n   = 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			drop_q      <= 1'b0;
			active_q    <= 1'b0;
			pos_q       <= '0;
			marker_q    <= '0;
			hdr1_q      <= '0;
			hdr2_q      <= '0;
			crc_q       <= '0;
		end else begin
			if (in_ch.ready) valid_s1 <= in_ch.valid;
			if (advance) begin
				out_valid_q <= emit;
				drop_q      <= drop_n;
				active_q    <= active_n;
				pos_q       <= pos_n;
				marker_q    <= marker_n;
				hdr1_q      <= hdr1_n;
				hdr2_q      <= hdr2_n;
				crc_q       <= crc_n;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready) begin
			byte_s1  <= in_ch.wire_byte;
			start_s1 <= in_ch.frame_start;
		end
		if (advance && emit) begin
			kind_q   <= kind_n;
			pbyte_q  <= (kind_n == RESULT_PAYLOAD) ? byte_s1 : 8'd0;
			pidx_q   <= (kind_n == RESULT_PAYLOAD) ? 6'(pos_b - HDR_BYTES) : 6'd0;
			rcheck_q <= (kind_n == RESULT_SUMMARY) ? byte_s1 : 8'd0;
			ok_q     <= (kind_n == RESULT_SUMMARY) && (crc_b == byte_s1);
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.result_kind     = kind_q;
	assign out_ch.payload_byte    = pbyte_q;
	assign out_ch.payload_index   = pidx_q;
	assign out_ch.frame_marker    = marker_q;
	assign out_ch.payload_length  = hdr1_q[7:2];
	assign out_ch.sequence_number = {hdr1_q[1:0], hdr2_q[7:5]};
	assign out_ch.frame_type      = hdr2_q[4:0];
	assign out_ch.received_check  = rcheck_q;
	assign out_ch.check_ok        = ok_q;

endmodule

// ===== src/escaped_frame_receiver_crc8_top.sv =====
// Escaped frame receiver with 8-bit running check: top level.
// The earliest result transfer follows an input transfer through the input reg, then the result reg.
// Throughput: one wire byte per cycle, set by the single-byte check update between stages.
// A result not taken holds the processing stage; one more byte waits in the input register.
// Reset (arst_n, asynchronous, active low) clears frame state and loads register defaults.
// Depends on efr_pkg, the channel interfaces, efr_cfg_regs and efr_frame_core.
module escaped_frame_receiver_crc8_top
	import efr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	efr_cfg_if.sink   cfg,
	efr_in_if.sink    in_ch,
	efr_out_if.source out_ch
);

	cfg_t cfg_w;

	efr_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_w)
	);

	efr_frame_core u_frame_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_i  (cfg_w),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	a_summary_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.result_kind == RESULT_SUMMARY)
		|-> (out_ch.payload_byte == 8'd0 && out_ch.payload_index == 6'd0))
		else $error("summary carries payload fields");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.result_kind == RESULT_PAYLOAD)
		|-> (out_ch.received_check == 8'd0 && !out_ch.check_ok))
		else $error("payload result carries check fields");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.result_kind == RESULT_PAYLOAD)
		|-> (out_ch.payload_index < out_ch.payload_length))
		else $error("payload index beyond header length");

endmodule
